FILE: hw/rtl/auto_prescaled_countdown_timer_unit_assert.svh
// Assertion helpers used by the checker file of this block.
`ifndef AUTO_PRESCALED_COUNTDOWN_TIMER_UNIT_ASSERT_SVH
`define AUTO_PRESCALED_COUNTDOWN_TIMER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define APCT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define APCT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/apct_pkg.sv
package apct_pkg;

  // Request kinds carried in tuser
  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_INIT   = 3'd1,
    REQ_START  = 3'd2,
    REQ_STOP   = 3'd3,
    REQ_QUERY  = 3'd4,
    REQ_RETIME = 3'd5
  } req_e;

  // Result codes
  typedef enum logic [1:0] {
    RC_OK     = 2'd0,
    RC_NOINIT = 2'd1,
    RC_BADPAR = 2'd2
  } rc_e;

  // Tick selection
  typedef enum logic [1:0] {
    RANGE_100US = 2'd0,
    RANGE_10US  = 2'd1,
    RANGE_1US   = 2'd2,
    RANGE_125NS = 2'd3
  } range_e;

  localparam int unsigned CountdownW = 32;
  localparam int unsigned AppliedW   = 23;
  localparam int unsigned CountW     = 16;
  localparam int unsigned RemainW    = 23;

  // Saturation limit of each range in microseconds
  localparam logic [AppliedW-1:0] MaxR0 = 23'd6400000;
  localparam logic [AppliedW-1:0] MaxR1 = 23'd640000;
  localparam logic [AppliedW-1:0] MaxR2 = 23'd64000;
  localparam logic [AppliedW-1:0] MaxR3 = 23'd8000;

  // Multiplicative inverses mod 2^32 for divisibility and exact division
  localparam logic [31:0] Inv5   = 32'hCCCCCCCD;
  localparam logic [31:0] Inv25  = 32'hC28F5C29;
  localparam logic [31:0] Inv125 = 32'h26E978D5;
  localparam logic [31:0] Lim5   = 32'hFFFFFFFF / 5;
  localparam logic [31:0] Lim25  = 32'hFFFFFFFF / 25;
  localparam logic [31:0] Lim125 = 32'hFFFFFFFF / 125;

  // Result item
  typedef struct packed {
    logic [31:0]        error_us;
    logic [RemainW-1:0] remaining_us;
    logic               expired;
    logic [1:0]         timer_status;
    rc_e                result_code;
  } result_t;

endpackage

FILE: hw/rtl/auto_prescaled_countdown_timer_unit.sv
// Countdown timer with automatic prescaling. Each item on the slave stream is a request
// (tuser: 0 clock tick, 1 init, 2 start, 3 stop, 4 query, 5 retime) and yields exactly one
// result item, in order. One item is taken every cycle while the output buffer is not full;
// the first stage checks divisibility of the countdown and saturates it,
// the second derives the period and the error, the third updates the timer state through
// its feedback loop, which sets the one-item-per-cycle rate. A two-entry output buffer
// holds results while the master side stalls, so tready never waits on m_tready_i
// combinationally. Init and retime pick a 100 us, 10 us, 1 us or 0.125 us tick; the
// prescaler ratio follows from CORE_CLOCK_HZ. Registers: 0x0 oneshot_mode, 0x4 irq_enabled.
module auto_prescaled_countdown_timer_unit #(
  parameter int unsigned CORE_CLOCK_HZ = 72000000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // [31:0] countdown_us
  input  logic [2:0]  s_tuser_i,   // [2:0] req_type
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [63:0] m_tdata_o,   // [1:0] result_code, [3:2] timer_status, [4] expired,
                                   // [27:5] remaining_us, [59:28] error_us, [63:60] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = apct_pkg::CountW;
  localparam int unsigned AW = apct_pkg::AppliedW;

  // Prescaler ratios, clamped to the counter width and to at least one
  localparam int unsigned RawR0 = CORE_CLOCK_HZ / 10000;
  localparam int unsigned RawR1 = CORE_CLOCK_HZ / 100000;
  localparam int unsigned RawR2 = CORE_CLOCK_HZ / 1000000;
  localparam int unsigned RawR3 = CORE_CLOCK_HZ / 8000000;
  localparam logic [CW-1:0] DivR0 = (RawR0 == 0) ? CW'(1) : (RawR0 > 65535) ? '1 : CW'(RawR0);
  localparam logic [CW-1:0] DivR1 = (RawR1 == 0) ? CW'(1) : (RawR1 > 65535) ? '1 : CW'(RawR1);
  localparam logic [CW-1:0] DivR2 = (RawR2 == 0) ? CW'(1) : (RawR2 > 65535) ? '1 : CW'(RawR2);
  localparam logic [CW-1:0] DivR3 = (RawR3 == 0) ? CW'(1) : (RawR3 > 65535) ? '1 : CW'(RawR3);

  localparam logic [CW-1:0] Inv5Lo  = apct_pkg::Inv5[CW-1:0];
  localparam logic [CW-1:0] Inv25Lo = apct_pkg::Inv25[CW-1:0];

  typedef enum logic [1:0] {
    ST_UNINIT  = 2'd0,
    ST_IDLE    = 2'd1,
    ST_RUNNING = 2'd2,
    ST_EXPIRED = 2'd3
  } state_e;

  // Pipeline enable: stall everything while the output buffer is full
  logic en;
  logic fire_c;

  // Configuration registers
  logic oneshot_q, irq_q;

  // Stage A signals
  logic [31:0]           m5_a, m25_a, m125_a;
  logic                  div10_a, div100_a, div1000_a;
  apct_pkg::range_e      range_a;
  logic [AW-1:0]         cap_a, applied_a;
  logic                  v_a_q;
  logic [2:0]            req_a_q;
  logic [31:0]           cd_a_q;
  logic [AW-1:0]         applied_a_q;
  apct_pkg::range_e      range_a_q;
  logic                  zero_a_q;

  // Stage B signals
  logic [CW-1:0]         q100_b, q10_b;
  logic [CW-1:0]         period_b;
  logic                  v_b_q;
  logic [2:0]            req_b_q;
  apct_pkg::range_e      range_b_q;
  logic                  zero_b_q;
  logic [CW-1:0]         period_b_q;
  logic [31:0]           err_b_q;

  // Timer state
  state_e                state_q, state_d;
  apct_pkg::range_e      range_q, range_d;
  logic [CW-1:0]         period_q, period_d;
  logic [CW-1:0]         pc_q, pc_d;
  logic [CW-1:0]         dc_q, dc_d;
  logic [CW-1:0]         div_c, pc_inc;
  logic                  init_ok;
  apct_pkg::result_t     res_c;

  // Output buffer
  logic                  out_v_q, skid_v_q;
  apct_pkg::result_t     out_q, skid_q;
  logic                  take;

  assign en         = ~skid_v_q;
  assign s_tready_o = en;
  assign fire_c     = en & v_b_q;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {31'b0, irq_q} : {31'b0, oneshot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oneshot_q <= 1'b0;
      irq_q     <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) irq_q <= pwdata[0];
      else          oneshot_q <= pwdata[0];
    end
  end

  // Stage A: divisibility tests, tick selection and saturation
  assign m5_a      = s_tdata_i * apct_pkg::Inv5;
  assign m25_a     = s_tdata_i * apct_pkg::Inv25;
  assign m125_a    = s_tdata_i * apct_pkg::Inv125;
  assign div10_a   = ~s_tdata_i[0] & (m5_a <= apct_pkg::Lim5);
  assign div100_a  = (s_tdata_i[1:0] == 2'b00) & (m25_a <= apct_pkg::Lim25);
  assign div1000_a = (s_tdata_i[2:0] == 3'b000) & (m125_a <= apct_pkg::Lim125);

  always_comb begin
    if (div1000_a) begin
      range_a = apct_pkg::RANGE_100US;
      cap_a   = apct_pkg::MaxR0;
    end else if (div100_a) begin
      range_a = apct_pkg::RANGE_10US;
      cap_a   = apct_pkg::MaxR1;
    end else if (div10_a) begin
      range_a = apct_pkg::RANGE_1US;
      cap_a   = apct_pkg::MaxR2;
    end else begin
      range_a = apct_pkg::RANGE_125NS;
      cap_a   = apct_pkg::MaxR3;
    end
  end

  assign applied_a = (s_tdata_i > {{(32-AW){1'b0}}, cap_a}) ? cap_a : s_tdata_i[AW-1:0];

  // Stage B: period in ticks (exact division of a multiple) and error
  assign q100_b = CW'(applied_a_q[CW+1:2] * Inv25Lo);
  assign q10_b  = CW'(applied_a_q[CW:1] * Inv5Lo);

  always_comb begin
    case (range_a_q)
      apct_pkg::RANGE_100US: period_b = q100_b;
      apct_pkg::RANGE_10US:  period_b = q10_b;
      apct_pkg::RANGE_1US:   period_b = applied_a_q[CW-1:0];
      apct_pkg::RANGE_125NS: period_b = {applied_a_q[CW-4:0], 3'b000};
      default:               period_b = applied_a_q[CW-1:0];
    endcase
  end

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
    end else if (en) begin
      v_a_q <= s_tvalid_i;
      v_b_q <= v_a_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      req_a_q     <= s_tuser_i;
      cd_a_q      <= s_tdata_i;
      applied_a_q <= applied_a;
      range_a_q   <= range_a;
      zero_a_q    <= (s_tdata_i == 32'd0);
      req_b_q     <= req_a_q;
      range_b_q   <= range_a_q;
      zero_b_q    <= zero_a_q;
      period_b_q  <= period_b;
      err_b_q     <= cd_a_q - {{(32-AW){1'b0}}, applied_a_q};
    end
  end

  // Stage C: timer update and result
  always_comb begin
    case (range_q)
      apct_pkg::RANGE_100US: div_c = DivR0;
      apct_pkg::RANGE_10US:  div_c = DivR1;
      apct_pkg::RANGE_1US:   div_c = DivR2;
      apct_pkg::RANGE_125NS: div_c = DivR3;
      default:               div_c = DivR0;
    endcase
  end

  assign pc_inc  = pc_q + CW'(1);
  assign init_ok = ~zero_b_q & ~(oneshot_q & ~irq_q);

  always_comb begin
    state_d  = state_q;
    range_d  = range_q;
    period_d = period_q;
    pc_d     = pc_q;
    dc_d     = dc_q;
    res_c    = '0;
    res_c.result_code = apct_pkg::RC_OK;

    case (apct_pkg::req_e'(req_b_q))
      apct_pkg::REQ_TICK: begin
        if (state_q == ST_RUNNING) begin
          if (pc_inc < div_c) begin
            pc_d = pc_inc;
          end else begin
            pc_d = '0;
            if (dc_q != '0) begin
              dc_d = dc_q - CW'(1);
            end else begin
              dc_d = period_q - CW'(1);
              if (irq_q) begin
                res_c.expired = 1'b1;
                if (oneshot_q) begin
                  pc_d    = '0;
                  dc_d    = '0;
                  state_d = ST_EXPIRED;
                end
              end
            end
          end
        end
      end
      apct_pkg::REQ_INIT: begin
        if (!init_ok) begin
          res_c.result_code = apct_pkg::RC_BADPAR;
        end else begin
          if (state_q == ST_RUNNING) begin
            pc_d = '0;
            dc_d = '0;
          end
          range_d        = range_b_q;
          period_d       = period_b_q;
          res_c.error_us = err_b_q;
          state_d        = ST_IDLE;
        end
      end
      apct_pkg::REQ_START: begin
        if (state_q == ST_UNINIT) begin
          res_c.result_code = apct_pkg::RC_NOINIT;
        end else begin
          state_d = ST_RUNNING;
          pc_d    = '0;
          dc_d    = period_q - CW'(1);
        end
      end
      apct_pkg::REQ_STOP: begin
        if (state_q == ST_UNINIT) begin
          res_c.result_code = apct_pkg::RC_NOINIT;
        end else if (state_q != ST_IDLE) begin
          pc_d    = '0;
          dc_d    = '0;
          state_d = ST_IDLE;
        end
      end
      apct_pkg::REQ_QUERY: begin
        if (state_q == ST_UNINIT) begin
          res_c.result_code = apct_pkg::RC_NOINIT;
        end else begin
          case (range_q)
            apct_pkg::RANGE_100US:
              res_c.remaining_us = apct_pkg::RemainW'({7'b0, dc_q} * 23'd100);
            apct_pkg::RANGE_10US:
              res_c.remaining_us = apct_pkg::RemainW'({7'b0, dc_q} * 23'd10);
            apct_pkg::RANGE_1US:
              res_c.remaining_us = {7'b0, dc_q};
            apct_pkg::RANGE_125NS:
              res_c.remaining_us = {10'b0, dc_q[CW-1:3]};
            default:
              res_c.remaining_us = '0;
          endcase
        end
      end
      apct_pkg::REQ_RETIME: begin
        if (state_q == ST_UNINIT) begin
          res_c.result_code = apct_pkg::RC_NOINIT;
        end else begin
          if (init_ok) begin
            range_d        = range_b_q;
            period_d       = period_b_q;
            res_c.error_us = err_b_q;
            state_d        = ST_IDLE;
            pc_d           = '0;
            dc_d           = (state_q == ST_RUNNING) ? '0 : dc_q;
          end
          // Restart with the settings now in force
          if (state_q == ST_RUNNING) begin
            state_d = ST_RUNNING;
            pc_d    = '0;
            dc_d    = period_d - CW'(1);
          end else if (init_ok) begin
            pc_d = pc_q;
          end
        end
      end
      default: begin
        res_c.result_code = apct_pkg::RC_BADPAR;
      end
    endcase

    res_c.timer_status = state_d;
  end

  // Hold timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_UNINIT;
      range_q  <= apct_pkg::RANGE_100US;
      period_q <= '0;
      pc_q     <= '0;
      dc_q     <= '0;
    end else if (fire_c) begin
      state_q  <= state_d;
      range_q  <= range_d;
      period_q <= period_d;
      pc_q     <= pc_d;
      dc_q     <= dc_d;
    end
  end

  // Output register with one skid entry
  assign take = out_v_q & m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || take) begin
      out_v_q  <= skid_v_q | fire_c;
      skid_v_q <= 1'b0;
    end else if (fire_c) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      out_q <= skid_v_q ? skid_q : res_c;
    end else if (fire_c) begin
      skid_q <= res_c;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = {4'b0, out_q.error_us, out_q.remaining_us, out_q.expired,
                       out_q.timer_status, out_q.result_code};

endmodule

FILE: hw/rtl/apct_checker.sv
`include "auto_prescaled_countdown_timer_unit_assert.svh"

module apct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [63:0] m_tdata_o
);

  logic       rc_ok;
  logic [1:0] rc;

  assign rc    = m_tdata_o[1:0];
  assign rc_ok = (rc == apct_pkg::RC_OK);

  // Result code is always one of the defined codes
  `APCT_ASSERT_IMPL(a_rc_defined, clk_i, rst_ni, m_tvalid_o,
    rc_ok || (rc == apct_pkg::RC_NOINIT) || (rc == apct_pkg::RC_BADPAR),
    "undefined result code")

  // An expiry pulse only comes with a plain ok tick result
  `APCT_ASSERT_IMPL(a_expiry_clean, clk_i, rst_ni, m_tvalid_o && m_tdata_o[4],
    rc_ok && (m_tdata_o[59:5] == '0), "expiry pulse with other result fields set")

  // A failed request reports neither time nor error
  `APCT_ASSERT_IMPL(a_fail_quiet, clk_i, rst_ni, m_tvalid_o && !rc_ok,
    (m_tdata_o[63:4] == '0), "failed request carries payload")

  // A stalled result holds
  `APCT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i,
    m_tvalid_o && $stable(m_tdata_o), "result changed while stalled")

endmodule

bind auto_prescaled_countdown_timer_unit apct_checker u_apct_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

FILE: tb/auto_prescaled_countdown_timer_checker.sv
`timescale 1ns / 100ps

// Watch the request, result and register channels of the timer, predict each
// result and compare it with what the block returns.
module auto_prescaled_countdown_timer_checker
  import apct_pkg::*;
#(
  parameter int unsigned CoreClockHz = 72000000,
  parameter logic [2:0]  OneshotAddr = 3'h0,
  parameter logic [2:0]  IrqAddr     = 3'h4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          pulses_o
);

  localparam logic [1:0] StUninit  = 2'd0;
  localparam logic [1:0] StIdle    = 2'd1;
  localparam logic [1:0] StRunning = 2'd2;
  localparam logic [1:0] StExpired = 2'd3;

  // Predicted timer state and register copies
  logic        oneshot_q;
  logic        irq_q;
  logic [1:0]  status_q;
  range_e      range_q;
  logic [15:0] presc_reload_q;
  logic [15:0] presc_cnt_q;
  logic [15:0] period_q;
  logic [15:0] down_q;

  result_t     timer_results_q[$];
  bit          result_bad;

  function automatic logic [15:0] prescale_ratio(input int unsigned per_ms);
    int unsigned r;
    r = CoreClockHz / per_ms / 1000;
    if (r > 32'hFFFF) r = 32'hFFFF;
    return r[15:0];
  endfunction

  task automatic clear_counters();
    presc_cnt_q = '0;
    down_q      = '0;
  endtask

  task automatic restart_count();
    status_q    = StRunning;
    presc_cnt_q = '0;
    down_q      = period_q - 16'd1;
  endtask

  // Pick the tick from the divisibility of the countdown and saturate it
  task automatic apply_countdown(input logic [31:0] req, output rc_e rc,
                                 output logic [31:0] err);
    logic [31:0] applied;
    applied = req;
    err     = '0;
    if (req == 32'd0 || (oneshot_q && !irq_q)) begin
      rc = RC_BADPAR;
    end else begin
      if (status_q == StRunning) clear_counters();
      if (req % 32'd1000 == 32'd0) begin
        if (applied > MaxR0) applied = 32'(MaxR0);
        range_q        = RANGE_100US;
        presc_reload_q = prescale_ratio(10);
        period_q       = 16'(applied / 32'd100);
      end else if (req % 32'd100 == 32'd0) begin
        if (applied > MaxR1) applied = 32'(MaxR1);
        range_q        = RANGE_10US;
        presc_reload_q = prescale_ratio(100);
        period_q       = 16'(applied / 32'd10);
      end else if (req % 32'd10 == 32'd0) begin
        if (applied > MaxR2) applied = 32'(MaxR2);
        range_q        = RANGE_1US;
        presc_reload_q = prescale_ratio(1000);
        period_q       = 16'(applied);
      end else begin
        if (applied > MaxR3) applied = 32'(MaxR3);
        range_q        = RANGE_125NS;
        presc_reload_q = prescale_ratio(8000);
        period_q       = 16'(applied * 32'd8);
      end
      err      = req - applied;
      status_q = StIdle;
      rc       = RC_OK;
    end
  endtask

  // Advance the prescaler and the down counter for a clock tick request
  task automatic advance_tick(output logic pulse);
    logic [15:0] div;
    pulse = 1'b0;
    div   = (presc_reload_q == 16'd0) ? 16'd1 : presc_reload_q;
    if (status_q == StRunning) begin
      presc_cnt_q = presc_cnt_q + 16'd1;
      if (presc_cnt_q >= div) begin
        presc_cnt_q = '0;
        if (down_q != 16'd0) begin
          down_q = down_q - 16'd1;
        end else begin
          down_q = period_q - 16'd1;
          if (irq_q) begin
            pulse = 1'b1;
            if (oneshot_q) begin
              clear_counters();
              status_q = StExpired;
            end
          end
        end
      end
    end
  endtask

  task automatic predict_timer_step(input logic [2:0] kind, input logic [31:0] cd,
                                    output result_t res);
    rc_e         rc;
    rc_e         init_rc;
    logic        pulse;
    logic [22:0] rem;
    logic [31:0] err;
    logic        was_running;
    int unsigned tick_ns;
    logic [63:0] scaled;
    rc    = RC_OK;
    pulse = 1'b0;
    rem   = '0;
    err   = '0;
    case (kind)
      REQ_TICK: advance_tick(pulse);
      REQ_INIT: apply_countdown(cd, rc, err);
      REQ_START: begin
        if (status_q == StUninit) rc = RC_NOINIT;
        else restart_count();
      end
      REQ_STOP: begin
        if (status_q == StUninit) begin
          rc = RC_NOINIT;
        end else if (status_q != StIdle) begin
          clear_counters();
          status_q = StIdle;
        end
      end
      REQ_QUERY: begin
        if (status_q == StUninit) begin
          rc = RC_NOINIT;
        end else begin
          case (range_q)
            RANGE_100US: tick_ns = 100000;
            RANGE_10US:  tick_ns = 10000;
            RANGE_1US:   tick_ns = 1000;
            default:     tick_ns = 125;
          endcase
          scaled = 64'(tick_ns) * 64'(down_q) / 64'd1000;
          rem    = scaled[22:0];
        end
      end
      REQ_RETIME: begin
        if (status_q == StUninit) begin
          rc = RC_NOINIT;
        end else begin
          // a refused re-init keeps the settings but still restarts a running timer
          was_running = (status_q == StRunning);
          apply_countdown(cd, init_rc, err);
          if (init_rc != RC_OK) err = '0;
          if (was_running) restart_count();
        end
      end
      default: rc = RC_BADPAR;
    endcase
    res.result_code  = rc;
    res.timer_status = status_q;
    res.expired      = pulse;
    res.remaining_us = rem;
    res.error_us     = err;
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      result_bad = 1'b1;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Track registers, predict each accepted request and check each result
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      oneshot_q      = 1'b0;
      irq_q          = 1'b0;
      status_q       = StUninit;
      range_q        = RANGE_100US;
      presc_reload_q = '0;
      presc_cnt_q    = '0;
      period_q       = '0;
      down_q         = '0;
      timer_results_q.delete();
      fail_count_o  <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
      pulses_o      <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          OneshotAddr: oneshot_q = pwdata_i[0];
          IrqAddr:     irq_q     = pwdata_i[0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_timer_step(s_tuser_i, s_tdata_i, want);
        timer_results_q.push_back(want);
        if (want.expired) pulses_o <= pulses_o + 1;
      end
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i[59:0]);
        if (timer_results_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          $display("%0t: result with no request waiting, expected none actual %h",
                   $time, m_tdata_i);
        end else begin
          want       = timer_results_q.pop_front();
          result_bad = 1'b0;
          report_field("result_code", 32'(want.result_code), 32'(got.result_code));
          report_field("timer_status", 32'(want.timer_status), 32'(got.timer_status));
          report_field("expired", 32'(want.expired), 32'(got.expired));
          report_field("remaining_us", 32'(want.remaining_us), 32'(got.remaining_us));
          report_field("error_us", want.error_us, got.error_us);
          if (result_bad) fail_count_o <= fail_count_o + 1;
          checked_o <= checked_o + 1;
        end
      end
      pending_o <= timer_results_q.size();
    end
  end

endmodule

FILE: tb/auto_prescaled_countdown_timer_unit_tb.sv
`timescale 1ns / 100ps

module auto_prescaled_countdown_timer_unit_tb;
  import apct_pkg::*;

  localparam int unsigned CoreClockHz = 72000000;
  localparam logic [2:0]  RegOneshot  = 3'h0;
  localparam logic [2:0]  RegIrq      = 3'h4;
  localparam int          IdleLimit   = 5000;
  localparam int          LongHold    = 200;
  localparam int          PhaseItems  = 70;
  localparam int          NumPhases   = 8;
  localparam int          SettleLen   = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [31:0] s_tdata_i;   // [31:0] countdown_us
  logic [2:0]  s_tuser_i;   // [2:0] req_type
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [63:0] m_tdata_o;   // [1:0] result_code, [3:2] timer_status, [4] expired,
                            // [27:5] remaining_us, [59:28] error_us
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          checked;
  int          pulses;
  int          items_sent;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_go;
  int          stuck_cycles;

  auto_prescaled_countdown_timer_unit #(
    .CORE_CLOCK_HZ(CoreClockHz)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  auto_prescaled_countdown_timer_checker #(
    .CoreClockHz (CoreClockHz),
    .OneshotAddr (RegOneshot),
    .IrqAddr     (RegIrq)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_i   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .m_tvalid_i   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_i    (m_tdata_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .pulses_o     (pulses)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hold one long stall once hold_go is set, else stall at random
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    m_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // End the run when no item moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offer one request item and hold it until taken; call at a falling edge
  task automatic offer_request(input logic [2:0] kind, input logic [31:0] cd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= kind;
    s_tdata_i  <= cd;
    do @(posedge clk_i); while (!s_tready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every result is back and the pipeline is empty
  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleLen) @(negedge clk_i);
  endtask

  // Countdown over the whole field, biased toward each tick range, the extremes and small values
  function automatic logic [31:0] pick_countdown();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1, 10000) * 1000;
      2: return $urandom_range(1, 9999) * 100;
      3: return $urandom_range(1, 9999) * 10;
      4: return $urandom_range(1, 9999);
      5: return ($urandom_range(1) == 0) ? 32'd0 : 32'hFFFFFFFF;
      default: return $urandom_range(1, 9);
    endcase
  endfunction

  // Short countdowns so that the counter runs out within a sequence
  function automatic logic [31:0] short_countdown();
    if ($urandom_range(99) < 80) return $urandom_range(1, 4);
    return ($urandom_range(1) == 0) ? 32'd10 : 32'd20;
  endfunction

  // Init, start, then a run of clock ticks with requests mixed in
  task automatic run_timer_sequence();
    int n_ticks;
    int r;
    offer_request(REQ_INIT, short_countdown());
    offer_request(REQ_START, $urandom);
    n_ticks = $urandom_range(30, 120);
    repeat (n_ticks) begin
      r = $urandom_range(99);
      if (r < 88)      offer_request(REQ_TICK, $urandom);
      else if (r < 93) offer_request(REQ_QUERY, $urandom);
      else if (r < 95) offer_request(REQ_RETIME, short_countdown());
      else if (r < 97) offer_request(REQ_START, $urandom);
      else if (r < 98) offer_request(REQ_STOP, $urandom);
      else             offer_request(REQ_INIT, pick_countdown());
    end
    offer_request(REQ_QUERY, $urandom);
    if ($urandom_range(1) == 1) offer_request(REQ_STOP, $urandom);
  endtask

  initial begin : stimulus
    int ph;
    int phase_end;
    int r;
    rst_ni         = 1'b0;
    s_tvalid_i     = 1'b0;
    s_tdata_i      = '0;
    s_tuser_i      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Requests before init, unknown kinds and a zero countdown
    offer_request(REQ_TICK, 32'd0);
    offer_request(REQ_START, 32'hFFFFFFFF);
    offer_request(REQ_STOP, 32'd0);
    offer_request(REQ_QUERY, 32'd0);
    offer_request(REQ_RETIME, 32'd100);
    offer_request(3'd6, 32'hFFFFFFFF);
    offer_request(3'd7, 32'd0);
    offer_request(REQ_INIT, 32'd0);
    // Saturation in each range, query at the largest count
    offer_request(REQ_INIT, 32'hFFFFFFFF);
    offer_request(REQ_INIT, 32'd4294967000);
    offer_request(REQ_QUERY, 32'd0);
    offer_request(REQ_START, 32'd0);
    offer_request(REQ_QUERY, 32'd0);
    offer_request(REQ_TICK, 32'd0);
    offer_request(REQ_INIT, 32'd640100);
    offer_request(REQ_START, 32'd0);
    offer_request(REQ_RETIME, 32'd64010);
    offer_request(REQ_QUERY, 32'd0);
    offer_request(REQ_STOP, 32'd0);
    offer_request(REQ_STOP, 32'd0);
    offer_request(REQ_TICK, 32'd0);
    offer_request(REQ_RETIME, 32'd8001);
    drain_results();

    // One-shot without interrupt refuses init; retime still restarts
    write_reg(RegOneshot, 32'd1);
    offer_request(REQ_INIT, 32'd5);
    offer_request(REQ_START, 32'd0);
    offer_request(REQ_RETIME, 32'd3);
    offer_request(REQ_STOP, 32'd0);
    drain_results();

    // Cycle through register settings and pacing modes
    for (ph = 0; ph < NumPhases; ph++) begin
      write_reg(RegOneshot, {31'd0, ph[0] ^ ph[2]});
      write_reg(RegIrq, {31'd0, ~ph[1]});
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (ph == 4) hold_go = 1'b1;
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        r = $urandom_range(99);
        if (r < 55) begin
          run_timer_sequence();
        end else if (r < 75) begin
          offer_request(3'($urandom_range(7)), pick_countdown());
        end else if (r < 90) begin
          offer_request(($urandom_range(1) == 0) ? REQ_INIT : REQ_RETIME, pick_countdown());
        end else begin
          offer_request(REQ_QUERY, $urandom);
        end
      end
      drain_results();
    end

    $display("summary: %0d requests sent, %0d results checked, %0d expiry pulses",
             items_sent, checked, pulses);
    $display("summary: %0d phases over every register setting and pacing mode",
             NumPhases);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
